// ----- rtl/sfpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpm_pkg
// shared types and constants of the stereo frame pair matcher
// ----------------------------------------------------------------------------
package sfpm_pkg;

	localparam int DEPTH     = 32;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int PTS_W     = 33;
	localparam int TAG_W     = 16;
	localparam int TS_W      = 28;
	localparam int MBC_W     = 6;
	localparam int NEED_MAX  = DEPTH / 2;
	localparam int NEED_W    = (CNT_W > MBC_W) ? CNT_W : MBC_W;
	// pts / 90 as (pts / 2) / 45, with 2^38 / 45 = 2^32 + RECIP_LO rounded up
	localparam int HALF_W    = PTS_W - 1;
	localparam int QUO_W     = TS_W - 1;
	localparam int RECIP_SH  = 6;
	localparam logic [HALF_W-1:0] RECIP_LO = 32'h6C16_C16D;
	localparam int DIV_STEPS = 2;
	localparam int DCNT_W    = 2;
	localparam int IN_DW     = 56;
	localparam int OUT_DW    = 64;
	localparam int APB_DW    = 64;
	localparam int APB_AW    = 4;

	localparam logic REG_TOL = 1'b0;
	localparam logic REG_MBC = 1'b1;

	localparam logic [PTS_W-1:0] TOL_RESET = PTS_W'(3003);
	localparam logic [MBC_W-1:0] MBC_RESET = MBC_W'(3);

	typedef struct packed {
		logic             idr;
		logic [TAG_W-1:0] tag;
		logic [PTS_W-1:0] pts;
	} entry_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ACC,
		ST_PUSH,
		ST_CHECK,
		ST_SB_RD,
		ST_SB_LD,
		ST_SD,
		ST_FOUND,
		ST_DIV,
		ST_EMIT,
		ST_RM_DEP,
		ST_FULLCHK,
		ST_DROP_DEP,
		ST_SH_RD,
		ST_SH_WR
	} state_t;

	typedef struct packed {
		logic load_in;
		logic push_wr;
		logic sh_init;
		logic sh_best;
		logic sh_sel_dep;
		logic sh_rd;
		logic sh_wr;
		logic sh_done;
		logic srch_init;
		logic base_ld;
		logic dep_cmp;
		logic next_base;
		logic ts_start;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic in_dep;
		logic base_full;
		logic dep_full;
		logic can_match;
		logic sh_more;
		logic dep_more;
		logic base_more;
		logic found;
		logic div_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/sfpm_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpm_ram
// frame descriptor buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module sfpm_ram (
	input  logic                  clk,
	input  logic                  we,
	input  logic [sfpm_pkg::IDX_W-1:0] waddr,
	input  sfpm_pkg::entry_t      wdata,
	input  logic [sfpm_pkg::IDX_W-1:0] raddr,
	output sfpm_pkg::entry_t      rdata
);
	import sfpm_pkg::*;

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/sfpm_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpm_datapath
// buffers, fill counts, pair search, timestamp divider and result register
// ----------------------------------------------------------------------------
module sfpm_datapath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sfpm_pkg::cmd_t               cmd,
	output sfpm_pkg::sts_t               sts,
	input  logic                         in_action,
	input  logic [sfpm_pkg::PTS_W-1:0]   in_pts,
	input  logic [sfpm_pkg::TAG_W-1:0]   in_tag,
	input  logic                         in_idr,
	input  logic [sfpm_pkg::PTS_W-1:0]   tol,
	input  logic [sfpm_pkg::MBC_W-1:0]   mbc,
	input  logic                         out_ready,
	output logic                         out_valid,
	output logic [sfpm_pkg::TAG_W-1:0]   out_base_tag,
	output logic [sfpm_pkg::TAG_W-1:0]   out_dep_tag,
	output logic signed [sfpm_pkg::TS_W-1:0] out_ts,
	output logic                         out_key
);
	import sfpm_pkg::*;

	// latched item
	entry_t            in_q;
	logic              in_dep_q;

	logic [CNT_W-1:0]  bcnt_q, dcnt_q;
	logic [CNT_W-1:0]  bi_q, di_q, k_q;
	logic              sel_q;

	entry_t            cur_q;
	logic              found_q;
	logic [PTS_W-1:0]  best_pts_q;
	logic [CNT_W-1:0]  best_b_q, best_d_q;
	logic [TAG_W-1:0]  best_btag_q, best_dtag_q;
	logic              best_idr_q;

	logic [PTS_W-1:0]  off_q;
	logic              cap_q;

	logic [HALF_W-1:0]   dvd_q;
	logic [2*HALF_W-1:0] prod_q;
	logic [QUO_W-1:0]    quo_q;
	logic [DCNT_W-1:0]   dcnt_div_q;
	logic                neg_q;

	logic              ovalid_q;
	logic [TAG_W-1:0]  obtag_q, odtag_q;
	logic signed [TS_W-1:0] ots_q;
	logic              okey_q;

	entry_t            base_rd, dep_rd, push_data;
	logic              base_we, dep_we;
	logic [IDX_W-1:0]  base_waddr, dep_waddr, base_raddr, dep_raddr;
	logic [CNT_W-1:0]  k_p1, sel_cnt;
	logic [NEED_W-1:0] need;

	logic [PTS_W-1:0]  bp, dp, ad;
	logic              hit;
	logic [PTS_W-1:0]  ofs;
	logic [PTS_W:0]    diff;
	logic [PTS_W-1:0]  mag;
	logic [2*HALF_W-1:0] prod_d;
	logic [PTS_W-1:0]  qsum;
	logic [TS_W-1:0]   qv;

	assign k_p1    = k_q + CNT_W'(1);
	assign sel_cnt = sel_q ? dcnt_q : bcnt_q;

	assign push_data.idr = in_dep_q ? 1'b0 : in_q.idr;
	assign push_data.tag = in_q.tag;
	assign push_data.pts = in_q.pts;

	always_comb begin
		base_we    = 1'b0;
		dep_we     = 1'b0;
		base_waddr = bcnt_q[IDX_W-1:0];
		dep_waddr  = dcnt_q[IDX_W-1:0];
		if (cmd.push_wr) begin
			base_we = !in_dep_q;
			dep_we  = in_dep_q;
		end
		if (cmd.sh_wr) begin
			base_we    = !sel_q;
			dep_we     = sel_q;
			base_waddr = k_q[IDX_W-1:0];
			dep_waddr  = k_q[IDX_W-1:0];
		end
	end

	assign base_raddr = (cmd.sh_rd && !sel_q) ? k_p1[IDX_W-1:0] : bi_q[IDX_W-1:0];

	always_comb begin
		if (cmd.sh_rd && sel_q) begin
			dep_raddr = k_p1[IDX_W-1:0];
		end else if (cmd.base_ld) begin
			dep_raddr = '0;
		end else begin
			dep_raddr = di_q[IDX_W-1:0];
		end
	end

	sfpm_ram u_base_ram (
		.clk   (clk),
		.we    (base_we),
		.waddr (base_waddr),
		.wdata (cmd.sh_wr ? base_rd : push_data),
		.raddr (base_raddr),
		.rdata (base_rd)
	);

	sfpm_ram u_dep_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (dep_waddr),
		.wdata (cmd.sh_wr ? dep_rd : push_data),
		.raddr (dep_raddr),
		.rdata (dep_rd)
	);

	// pair compare on the dependent entry read last cycle
	assign bp  = cur_q.pts;
	assign dp  = dep_rd.pts;
	assign ad  = (bp >= dp) ? (bp - dp) : (dp - bp);
	assign hit = (ad <= tol) && (!found_q || (bp < best_pts_q));

	// matching threshold, capped at half depth
	always_comb begin
		if (NEED_W'(mbc) > NEED_W'(NEED_MAX)) begin
			need = NEED_W'(NEED_MAX);
		end else begin
			need = NEED_W'(mbc);
		end
	end

	// timestamp relative to the first emitted base pts
	assign ofs  = cap_q ? off_q : best_pts_q;
	assign diff = {1'b0, best_pts_q} - {1'b0, ofs};
	assign mag  = diff[PTS_W] ? PTS_W'(-diff) : diff[PTS_W-1:0];

	// magnitude / 90 by reciprocal multiply: a registered multiply, then a registered add
	assign prod_d = {(HALF_W)'(0), dvd_q} * {(HALF_W)'(0), RECIP_LO};
	assign qsum   = {1'b0, dvd_q} + {1'b0, prod_q[2*HALF_W-1:HALF_W]};
	assign qv     = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcnt_q     <= '0;
			dcnt_q     <= '0;
			bi_q       <= '0;
			di_q       <= '0;
			k_q        <= '0;
			sel_q      <= 1'b0;
			found_q    <= 1'b0;
			off_q      <= '0;
			cap_q      <= 1'b0;
			dcnt_div_q <= '0;
			ovalid_q   <= 1'b0;
		end else begin
			if (cmd.push_wr) begin
				if (in_dep_q) begin
					dcnt_q <= dcnt_q + CNT_W'(1);
				end else begin
					bcnt_q <= bcnt_q + CNT_W'(1);
				end
			end
			if (cmd.sh_init) begin
				sel_q <= cmd.sh_sel_dep;
				if (cmd.sh_best) begin
					k_q <= cmd.sh_sel_dep ? best_d_q : best_b_q;
				end else begin
					k_q <= '0;
				end
			end
			if (cmd.sh_wr) begin
				k_q <= k_p1;
			end
			if (cmd.sh_done) begin
				if (sel_q) begin
					dcnt_q <= dcnt_q - CNT_W'(1);
				end else begin
					bcnt_q <= bcnt_q - CNT_W'(1);
				end
			end
			if (cmd.srch_init) begin
				bi_q    <= '0;
				found_q <= 1'b0;
			end
			if (cmd.next_base) begin
				bi_q <= bi_q + CNT_W'(1);
			end
			if (cmd.base_ld) begin
				di_q <= CNT_W'(1);
			end
			if (cmd.dep_cmp) begin
				if (di_q < dcnt_q) begin
					di_q <= di_q + CNT_W'(1);
				end
				if (hit) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.ts_start) begin
				dcnt_div_q <= DCNT_W'(DIV_STEPS);
				if (!cap_q) begin
					off_q <= best_pts_q;
					cap_q <= 1'b1;
				end
			end else if (dcnt_div_q != '0) begin
				dcnt_div_q <= dcnt_div_q - DCNT_W'(1);
			end
			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_q.pts <= in_pts;
			in_q.tag <= in_tag;
			in_q.idr <= in_idr;
			in_dep_q <= in_action;
		end
		if (cmd.base_ld) begin
			cur_q <= base_rd;
		end
		if (cmd.dep_cmp && hit) begin
			best_pts_q  <= bp;
			best_b_q    <= bi_q;
			best_d_q    <= di_q - CNT_W'(1);
			best_btag_q <= cur_q.tag;
			best_idr_q  <= cur_q.idr;
			best_dtag_q <= dep_rd.tag;
		end
		if (cmd.ts_start) begin
			dvd_q <= mag[PTS_W-1:1];
			neg_q <= diff[PTS_W];
		end
		if (dcnt_div_q == DCNT_W'(DIV_STEPS)) begin
			prod_q <= prod_d;
		end
		if (dcnt_div_q == DCNT_W'(1)) begin
			quo_q <= qsum[RECIP_SH +: QUO_W];
		end
		if (cmd.out_load) begin
			obtag_q <= best_btag_q;
			odtag_q <= best_dtag_q;
			ots_q   <= qv;
			okey_q  <= best_idr_q;
		end
	end

	assign sts.in_dep    = in_dep_q;
	assign sts.base_full = bcnt_q == CNT_W'(DEPTH);
	assign sts.dep_full  = dcnt_q == CNT_W'(DEPTH);
	assign sts.can_match = (bcnt_q != '0) && (dcnt_q != '0) && (NEED_W'(bcnt_q) >= need);
	assign sts.sh_more   = k_p1 < sel_cnt;
	assign sts.dep_more  = di_q < dcnt_q;
	assign sts.base_more = (bi_q + CNT_W'(1)) < bcnt_q;
	assign sts.found     = found_q;
	assign sts.div_done  = dcnt_div_q == '0;
	assign sts.out_free  = !ovalid_q || out_ready;

	assign out_valid    = ovalid_q;
	assign out_base_tag = obtag_q;
	assign out_dep_tag  = odtag_q;
	assign out_ts       = ots_q;
	assign out_key      = okey_q;

endmodule

// ----- rtl/sfpm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfpm_ctrl
// sequencer for insert, search, emit and buffer compaction
// ----------------------------------------------------------------------------
module sfpm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sfpm_pkg::sts_t sts,
	output sfpm_pkg::cmd_t cmd
);
	import sfpm_pkg::*;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		ret_d    = ret_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_ACC;
				end
			end
			ST_ACC: begin
				// make room by dropping the oldest entry
				if (sts.in_dep ? sts.dep_full : sts.base_full) begin
					cmd.sh_init    = 1'b1;
					cmd.sh_sel_dep = sts.in_dep;
					ret_d          = ST_PUSH;
					state_d        = ST_SH_RD;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				cmd.push_wr = 1'b1;
				state_d     = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.can_match) begin
					cmd.srch_init = 1'b1;
					state_d       = ST_SB_RD;
				end else begin
					state_d = ST_FULLCHK;
				end
			end
			ST_SB_RD: begin
				state_d = ST_SB_LD;
			end
			ST_SB_LD: begin
				cmd.base_ld = 1'b1;
				state_d     = ST_SD;
			end
			ST_SD: begin
				cmd.dep_cmp = 1'b1;
				if (!sts.dep_more) begin
					if (sts.base_more) begin
						cmd.next_base = 1'b1;
						state_d       = ST_SB_RD;
					end else begin
						state_d = ST_FOUND;
					end
				end
			end
			ST_FOUND: begin
				if (sts.found) begin
					cmd.ts_start = 1'b1;
					state_d      = ST_DIV;
				end else begin
					state_d = ST_FULLCHK;
				end
			end
			ST_DIV: begin
				if (sts.div_done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.sh_init  = 1'b1;
					cmd.sh_best  = 1'b1;
					ret_d        = ST_RM_DEP;
					state_d      = ST_SH_RD;
				end
			end
			ST_RM_DEP: begin
				cmd.sh_init    = 1'b1;
				cmd.sh_best    = 1'b1;
				cmd.sh_sel_dep = 1'b1;
				ret_d          = ST_IDLE;
				state_d        = ST_SH_RD;
			end
			ST_FULLCHK: begin
				if (sts.base_full && sts.dep_full) begin
					cmd.sh_init = 1'b1;
					ret_d       = ST_DROP_DEP;
					state_d     = ST_SH_RD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_DROP_DEP: begin
				cmd.sh_init    = 1'b1;
				cmd.sh_sel_dep = 1'b1;
				ret_d          = ST_IDLE;
				state_d        = ST_SH_RD;
			end
			ST_SH_RD: begin
				if (sts.sh_more) begin
					cmd.sh_rd = 1'b1;
					state_d   = ST_SH_WR;
				end else begin
					cmd.sh_done = 1'b1;
					state_d     = ret_q;
				end
			end
			ST_SH_WR: begin
				cmd.sh_wr = 1'b1;
				state_d   = ST_SH_RD;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- rtl/stereo_frame_pts_pair_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stereo_frame_pts_pair_matcher
// pairs base-view and dependent-view frame descriptors by pts
// ----------------------------------------------------------------------------
// Each input item is one finished frame descriptor for the base view
// (tuser[0] = 0) or the dependent view (tuser[0] = 1). Descriptors go into
// two 32-entry buffers, oldest first; a full buffer loses its oldest entry.
// After each item, once enough base frames are held, every base/dependent
// pair is compared one pair a clock, with a pause to load each base frame,
// through a single compare unit, and the base frame with the lowest pts that
// has a dependent frame within match_tolerance is paired and sent out with a
// millisecond timestamp taken from the first pair ever emitted; the divide
// by 90 is a registered reciprocal multiply followed by a registered add.
// The time an item takes is set by the pair search loop and by the
// compaction of the buffers, which moves one entry at a time through a read
// state and a write state, plus any wait for the output register. The input
// is taken again only once the previous item is finished. A finished result
// is held in an output register, so an unread result blocks only the next
// result, not the next input item.
// ----------------------------------------------------------------------------
module stereo_frame_pts_pair_matcher (
	input  logic                          clk,
	input  logic                          arst_n,
	// input items
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [sfpm_pkg::IN_DW-1:0]    s_axis_tdata,  // frame_pts, frame_tag
	input  logic [1:0]                    s_axis_tuser,  // action, frame_is_idr
	// result items
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [sfpm_pkg::OUT_DW-1:0]   m_axis_tdata,  // base_tag, dependent_tag, timestamp_ms
	output logic                          m_axis_tuser,  // pair_is_keyframe
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfpm_pkg::APB_AW-1:0]   paddr,
	input  logic [sfpm_pkg::APB_DW-1:0]   pwdata,
	output logic [sfpm_pkg::APB_DW-1:0]   prdata,
	output logic                          pready
);
	import sfpm_pkg::*;

	// configuration registers
	logic [PTS_W-1:0] tol_q;
	logic [MBC_W-1:0] mbc_q;
	logic             cfg_wr;

	cmd_t cmd;
	sts_t sts;

	logic [TAG_W-1:0]       out_base_tag, out_dep_tag;
	logic signed [TS_W-1:0] out_ts;
	logic                   out_key;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	// registers sit at 8-byte spacing, selected by paddr[3]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
			mbc_q <= MBC_RESET;
		end else if (cfg_wr) begin
			case (paddr[3])
				REG_TOL: tol_q <= pwdata[PTS_W-1:0];
				REG_MBC: mbc_q <= pwdata[MBC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3])
			REG_TOL: prdata = APB_DW'(tol_q);
			REG_MBC: prdata = APB_DW'(mbc_q);
			default: prdata = '0;
		endcase
	end

	// sequencer
	sfpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// buffers, search and result register
	sfpm_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_action    (s_axis_tuser[0]),
		.in_pts       (s_axis_tdata[PTS_W-1:0]),
		.in_tag       (s_axis_tdata[PTS_W+TAG_W-1:PTS_W]),
		.in_idr       (s_axis_tuser[1]),
		.tol          (tol_q),
		.mbc          (mbc_q),
		.out_ready    (m_axis_tready),
		.out_valid    (m_axis_tvalid),
		.out_base_tag (out_base_tag),
		.out_dep_tag  (out_dep_tag),
		.out_ts       (out_ts),
		.out_key      (out_key)
	);

	// result packing, zero filled to whole bytes
	assign m_axis_tdata = {(OUT_DW-2*TAG_W-TS_W)'(0), out_ts, out_dep_tag, out_base_tag};
	assign m_axis_tuser = out_key;

`ifndef NO_ASSERTIONS
	// an item is never written into a full buffer
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push_wr |-> !(sts.in_dep ? sts.dep_full : sts.base_full))
		else $error("push into full buffer");

	// a result never overwrites one still waiting
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten");

	// the divider is only started for a real pair
	a_ts_found: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ts_start |-> sts.found)
		else $error("timestamp started without a pair");

	// a result is loaded only after the divider has finished
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.div_done)
		else $error("result loaded while divider busy");
`endif

endmodule
